[rtl/ced_pkg.sv]
// Package for the caret escape decoder: widths, character constants, the
// escape phase type and the small decode helpers. No dependencies.
package ced_pkg;

    localparam int CodeW = 21;
    localparam int HeldW = 7;
    localparam int ResMax = 3;
    localparam int CntW = 2;

    localparam logic [HeldW-1:0] ChCaret = 7'h5E;
    localparam logic [HeldW-1:0] ChZero = 7'h30;
    localparam logic [HeldW-1:0] ChNine = 7'h39;
    localparam logic [HeldW-1:0] ChLowA = 7'h61;
    localparam logic [HeldW-1:0] ChLowF = 7'h66;
    localparam logic [HeldW-1:0] ChLowAOff = 7'h57;  // 'a' minus ten
    localparam logic [CodeW-1:0] ChLineFeed = 21'h00000A;
    localparam logic [CodeW-1:0] ChCarriageRet = 21'h00000D;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2,
        PH_DIGIT = 2'd3
    } t_phase;

    typedef logic [CodeW-1:0] t_code;

    function automatic logic is_hex(input t_code c);
        logic lo_ok;
        lo_ok = ((c[HeldW-1:0] >= ChZero) && (c[HeldW-1:0] <= ChNine))
            || ((c[HeldW-1:0] >= ChLowA) && (c[HeldW-1:0] <= ChLowF));
        return (c[CodeW-1:HeldW] == '0) && lo_ok;
    endfunction

    function automatic logic [3:0] hex_val(input logic [HeldW-1:0] c);
        logic [HeldW-1:0] v;
        v = (c <= ChNine) ? (c - ChZero) : (c - ChLowAOff);
        return v[3:0];
    endfunction

    // Adding or subtracting 64 on a code below 128 only flips bit 6.
    function automatic t_code shift64(input logic [HeldW-1:0] c);
        return {{(CodeW-HeldW){1'b0}}, c ^ 7'h40};
    endfunction

    function automatic t_code map_lf(input t_code c);
        return (c == ChLineFeed) ? ChCarriageRet : c;
    endfunction

    function automatic t_code widen(input logic [HeldW-1:0] c);
        return {{(CodeW-HeldW){1'b0}}, c};
    endfunction

endpackage

[rtl/ced_in_if.sv]
// Input channel of the caret escape decoder: valid/ready with code and flush.
// Depends on ced_pkg.
interface ced_in_if import ced_pkg::*;;
    logic       valid;
    logic       ready;
    t_code      code;
    logic       flush;

    modport source (output valid, output code, output flush, input ready);
    modport sink (input valid, input code, input flush, output ready);
endinterface

[rtl/ced_out_if.sv]
// Result channel of the caret escape decoder: valid/ready with the decoded
// code, error and last flags. Depends on ced_pkg.
interface ced_out_if import ced_pkg::*;;
    logic       valid;
    logic       ready;
    t_code      out_code;
    logic       error;
    logic       last;

    modport source (output valid, output out_code, output error, output last, input ready);
    modport sink (input valid, input out_code, input error, input last, output ready);
endinterface

[rtl/caret_escape_decoder.sv]
// Top level of the caret escape decoder.
// Depends on ced_pkg, ced_in_if and ced_out_if.

// The decoder takes one character code per transfer and gives the decoded
// characters one per cycle while the output is ready. A transfer lands in an
// input register, is decoded in a single pass and its zero to three results
// are loaded into a result buffer that drains one result per cycle while the
// output is ready; the input side takes a new item every cycle as long as each
// item gives at most one result and the output is ready. An item that gives
// three results (a caret pair before a code of 128 or more) or two results
// holds the input while the buffer drains. The results of an item pass through
// the input register and then the result buffer, from which they are shown.
module caret_escape_decoder import ced_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ced_in_if.sink      i_in,
    ced_out_if.source   o_out
);

    logic              r_in_valid;
    t_code             r_in_code;
    logic              r_in_flush;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [HeldW-1:0]  r_held;
    logic [HeldW-1:0]  n_held;

    t_code             r_res_code [ResMax];
    logic              r_res_err  [ResMax];
    logic [CntW-1:0]   r_cnt;

    logic [CntW-1:0]   d_cnt;
    t_code             d_code [ResMax];
    logic              d_err  [ResMax];

    logic              w_pop;
    logic              w_load;

    assign w_pop  = o_out.valid && o_out.ready;
    assign w_load = r_in_valid
        && ((r_cnt == '0) || ((r_cnt == CntW'(1)) && o_out.ready));

    assign i_in.ready     = !r_in_valid || w_load;
    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_code = r_res_code[0];
    assign o_out.error    = r_res_err[0];
    assign o_out.last     = (r_cnt == CntW'(1));

    // Single-pass decode of the registered item against the escape state.
    always_comb begin
        logic hex_in;
        hex_in  = is_hex(r_in_code);
        d_cnt   = '0;
        n_phase = r_phase;
        n_held  = r_held;
        for (int k = 0; k < ResMax; k++) begin
            d_code[k] = '0;
            d_err[k]  = 1'b0;
        end
        if (r_in_flush) begin
            n_phase = PH_IDLE;
            n_held  = '0;
            case (r_phase)
                PH_ONE, PH_TWO: begin
                    d_cnt    = CntW'(1);
                    d_err[0] = 1'b1;
                end
                PH_DIGIT: begin
                    d_cnt     = CntW'(1);
                    d_code[0] = map_lf(shift64(r_held));
                end
                default: begin
                    d_cnt = '0;
                end
            endcase
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (r_in_code == widen(ChCaret)) begin
                        n_phase = PH_ONE;
                    end else begin
                        d_cnt     = CntW'(1);
                        d_code[0] = map_lf(r_in_code);
                    end
                end
                PH_ONE: begin
                    if (r_in_code == widen(ChCaret)) begin
                        n_phase = PH_TWO;
                    end else begin
                        n_phase   = PH_IDLE;
                        d_cnt     = CntW'(2);
                        d_code[0] = widen(ChCaret);
                        d_code[1] = map_lf(r_in_code);
                    end
                end
                PH_TWO: begin
                    n_phase = PH_IDLE;
                    if (r_in_code[CodeW-1:HeldW] != '0) begin
                        d_cnt     = CntW'(3);
                        d_code[0] = widen(ChCaret);
                        d_code[1] = widen(ChCaret);
                        d_code[2] = r_in_code;
                    end else if (hex_in) begin
                        n_phase = PH_DIGIT;
                        n_held  = r_in_code[HeldW-1:0];
                    end else begin
                        d_cnt     = CntW'(1);
                        d_code[0] = map_lf(shift64(r_in_code[HeldW-1:0]));
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_held  = '0;
                    if (hex_in) begin
                        // The two digit values side by side spell the byte.
                        d_cnt     = CntW'(1);
                        d_code[0] = map_lf(t_code'({hex_val(r_held),
                                                    hex_val(r_in_code[HeldW-1:0])}));
                    end else begin
                        d_code[0] = map_lf(shift64(r_held));
                        if (r_in_code == widen(ChCaret)) begin
                            n_phase = PH_ONE;
                            d_cnt   = CntW'(1);
                        end else begin
                            d_cnt     = CntW'(2);
                            d_code[1] = map_lf(r_in_code);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_held     <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_load) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_cnt   <= d_cnt;
            end else if (w_pop) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    // Payload registers: the input register and the result buffer.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_code  <= i_in.code;
            r_in_flush <= i_in.flush;
        end
        if (w_load) begin
            for (int k = 0; k < ResMax; k++) begin
                r_res_code[k] <= d_code[k];
                r_res_err[k]  <= d_err[k];
            end
        end else if (w_pop) begin
            for (int k = 0; k < ResMax - 1; k++) begin
                r_res_code[k] <= r_res_code[k+1];
                r_res_err[k]  <= r_res_err[k+1];
            end
        end
    end

    // An error result always carries a zero code.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.error |-> o_out.out_code == '0)
        else $error("error result with nonzero code");

    // Line feed never leaves the block.
    a_no_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.out_code != ChLineFeed)
        else $error("line feed on output");

    // A held digit exists only in the digit phase.
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_DIGIT |-> r_held == '0)
        else $error("held digit outside digit phase");

    // A stalled result stays in place, also when it is the last.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(r_cnt))
        else $error("result buffer changed while stalled");

    // Input is held off only while an item waits in the input register.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && r_cnt != '0)
        else $error("input stalled without a waiting item");

endmodule

[sim/ced_decode_check.sv]
`timescale 1ns / 1ps
// Result checker for the caret escape decoder: predicts the characters that each
// input transfer decodes to and compares them with the result channel.
// Depends on ced_pkg, ced_in_if and ced_out_if.
module ced_decode_check import ced_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ced_in_if    i_in,
    ced_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_code code;
        logic  err;
        logic  last;
    } t_decoded;

    t_decoded         decoded_q[$];
    t_phase           esc_phase;
    logic [HeldW-1:0] held_char;
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic bit is_hex_char(input t_code c);
        return (c >= ChZero && c <= ChNine) || (c >= ChLowA && c <= ChLowF);
    endfunction

    function automatic int digit_value(input logic [HeldW-1:0] c);
        if (c <= ChNine) begin
            return int'(c) - int'(ChZero);
        end
        return int'(c) - int'(ChLowA) + 10;
    endfunction

    function automatic t_code flip64(input logic [HeldW-1:0] c);
        t_code v;
        v = t_code'(c);
        return (v < 64) ? t_code'(v + 64) : t_code'(v - 64);
    endfunction

    function automatic void push_char(input t_code c, input logic err);
        t_decoded d;
        d.code = (c == ChLineFeed) ? ChCarriageRet : c;
        if (err) begin
            d.code = '0;
        end
        d.err = err;
        d.last = 1'b0;
        decoded_q.push_back(d);
    endfunction

    function automatic void take_plain(input t_code c);
        if (c == t_code'(ChCaret)) begin
            esc_phase = PH_ONE;
        end else begin
            push_char(c, 1'b0);
        end
    endfunction

    function automatic void predict_item(input t_code c, input logic fl);
        int               first;
        logic [HeldW-1:0] held;
        first = decoded_q.size();
        if (fl) begin
            if (esc_phase == PH_ONE || esc_phase == PH_TWO) begin
                push_char('0, 1'b1);
            end else if (esc_phase == PH_DIGIT) begin
                push_char(flip64(held_char), 1'b0);
            end
            esc_phase = PH_IDLE;
            held_char = '0;
        end else begin
            case (esc_phase)
                PH_IDLE: begin
                    take_plain(c);
                end
                PH_ONE: begin
                    if (c == t_code'(ChCaret)) begin
                        esc_phase = PH_TWO;
                    end else begin
                        push_char(t_code'(ChCaret), 1'b0);
                        esc_phase = PH_IDLE;
                        take_plain(c);
                    end
                end
                PH_TWO: begin
                    esc_phase = PH_IDLE;
                    if (c >= 128) begin
                        push_char(t_code'(ChCaret), 1'b0);
                        push_char(t_code'(ChCaret), 1'b0);
                        push_char(c, 1'b0);
                    end else if (is_hex_char(c)) begin
                        held_char = c[HeldW-1:0];
                        esc_phase = PH_DIGIT;
                    end else begin
                        push_char(flip64(c[HeldW-1:0]), 1'b0);
                    end
                end
                default: begin
                    held = held_char;
                    esc_phase = PH_IDLE;
                    held_char = '0;
                    if (is_hex_char(c)) begin
                        push_char(t_code'(digit_value(held) * 16 + digit_value(c[HeldW-1:0])),
                                  1'b0);
                    end else begin
                        // A single digit falls back to the plain shift, and the
                        // current code starts over as ordinary text.
                        push_char(flip64(held), 1'b0);
                        take_plain(c);
                    end
                end
            endcase
        end
        if (decoded_q.size() > first) begin
            decoded_q[decoded_q.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_decoded want;
        if (!i_rst_n) begin
            esc_phase = PH_IDLE;
            held_char = '0;
            decoded_q.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                predict_item(i_in.code, i_in.flush);
            end
            if (i_out.valid && i_out.ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result: code %h error %b last %b",
                             $time, i_out.out_code, i_out.error, i_out.last);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out.out_code !== want.code) begin
                        $display("%0t: out_code mismatch: expected %h, actual %h",
                                 $time, want.code, i_out.out_code);
                        mismatches++;
                    end
                    if (i_out.error !== want.err) begin
                        $display("%0t: error mismatch: expected %b, actual %b",
                                 $time, want.err, i_out.error);
                        mismatches++;
                    end
                    if (i_out.last !== want.last) begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, i_out.last);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

[sim/caret_escape_decoder_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the caret escape decoder: clock, reset, stimulus, flow control
// and the verdict. Depends on ced_pkg, ced_in_if, ced_out_if, caret_escape_decoder
// and ced_decode_check.
module caret_escape_decoder_tb;
    import ced_pkg::*;

    localparam int TotalItems = 310;
    localparam int QuietTail = 50;
    localparam int LongHold = 60;
    localparam int MaxCode = 1114111;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    bit   pace_gaps;
    bit   hold_req;
    bit   pressed;
    int   sent;

    ced_in_if  in_ch();
    ced_out_if out_ch();

    caret_escape_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ced_decode_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic t_code any_hex();
        int d;
        d = $urandom_range(0, 15);
        return (d < 10) ? t_code'(int'(ChZero) + d) : t_code'(int'(ChLowA) + d - 10);
    endfunction

    function automatic t_code high_code();
        if ($urandom_range(0, 3) == 0) begin
            return t_code'($urandom_range(128, MaxCode));
        end
        return t_code'($urandom_range(128, 255));
    endfunction

    function automatic t_code any_code();
        case ($urandom_range(0, 9))
            0, 1: return t_code'($urandom_range(0, MaxCode));
            2: return ChLineFeed;
            3: return t_code'(ChCaret);
            4: return any_hex();
            default: return t_code'($urandom_range(0, 127));
        endcase
    endfunction

    // One input transfer, with an optional run of idle cycles ahead of it.
    task automatic send(input t_code c, input logic fl);
        int gap;
        gap = (pace_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.code <= c;
        in_ch.flush <= fl;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic send_pair();
        send(t_code'(ChCaret), 1'b0);
        send(t_code'(ChCaret), 1'b0);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : sink_side
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall = LongHold;
            end else if (stall == 0 && pace_gaps && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 8);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.code = '0;
        in_ch.flush = 1'b0;
        pace_gaps = 1'b1;
        hold_req = 1'b0;
        pressed = 1'b0;
        sent = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero, the largest code the bench uses (MaxCode), and the line feed mapping.
        send('0, 1'b0);
        send(t_code'(MaxCode), 1'b0);
        send(ChLineFeed, 1'b0);
        // Lone caret before ordinary text.
        send(t_code'(ChCaret), 1'b0);
        send(t_code'("x"), 1'b0);
        // Caret pair before a letter that shifts down to a line feed.
        send_pair();
        send(t_code'("J"), 1'b0);
        // Caret pair before a code of 128 passes all three through.
        send_pair();
        send(t_code'(128), 1'b0);
        // Two hex digits, one of them a nine.
        send_pair();
        send(t_code'(ChNine), 1'b0);
        send(t_code'(ChLowA), 1'b0);
        // A single hex digit followed by a caret, then flushed inside that caret.
        send_pair();
        send(t_code'(ChLowF), 1'b0);
        send(t_code'(ChCaret), 1'b0);
        send(t_code'($urandom_range(0, MaxCode)), 1'b1);
        // Flush after a caret pair, after a held digit, and while idle.
        send_pair();
        send('0, 1'b1);
        send_pair();
        send(t_code'(ChZero), 1'b0);
        send(t_code'(MaxCode), 1'b1);
        send('0, 1'b1);

        while (sent < TotalItems) begin
            if (sent >= TotalItems - QuietTail) begin
                pace_gaps = 1'b0;
            end
            if (!pressed && sent >= 150) begin
                // Hold the result side off while three-result items pile up.
                pressed = 1'b1;
                hold_req = 1'b1;
                repeat (6) begin
                    send_pair();
                    send(high_code(), 1'b0);
                end
            end
            case ($urandom_range(0, 9))
                0, 1: send(any_code(), 1'b0);
                2, 3: begin
                    send_pair();
                    send(any_hex(), 1'b0);
                    send(any_hex(), 1'b0);
                end
                4: begin
                    send_pair();
                    send(t_code'($urandom_range(0, 127)), 1'b0);
                end
                5: begin
                    send_pair();
                    send(high_code(), 1'b0);
                end
                6: begin
                    send(t_code'(ChCaret), 1'b0);
                    send(any_code(), 1'b0);
                end
                7: begin
                    send_pair();
                    send(any_hex(), 1'b0);
                    send(any_code(), 1'b0);
                end
                8: send(t_code'($urandom_range(0, MaxCode)), 1'b1);
                default: begin
                    send(t_code'(ChCaret), 1'b0);
                    if ($urandom_range(0, 1) == 1) begin
                        send(t_code'(ChCaret), 1'b0);
                        if ($urandom_range(0, 1) == 1) begin
                            send(any_hex(), 1'b0);
                        end
                    end
                    send(t_code'($urandom_range(0, MaxCode)), 1'b1);
                end
            endcase
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
